>>> rtl/core/fsft_pkg.sv
`default_nettype none

package fsft_pkg;

  localparam int unsigned TICKS_DEF = 10000000;

  localparam int TS_W       = 64;
  localparam int STEP_W     = 24;
  localparam int FREQ_W     = 32;
  localparam int MAXD_W     = 29;
  localparam int UPD_W      = 10;
  localparam int FRM_W      = 32;
  localparam int ISS_W      = STEP_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // digit width of the serial adders
  localparam int DIG_W = 4;
  localparam int MX_W  = ((MAXD_W + DIG_W - 1) / DIG_W) * DIG_W;

  localparam int STEP_RATE = 60;
  localparam int SNAP_DIV  = 4000;

  localparam logic [FREQ_W-1:0] FREQ_RST = 32'd10000000;
  localparam logic [MAXD_W-1:0] MAXD_RST = 29'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_STEP,
    REG_TARGET_STEP,
    REG_COUNTER_FREQ,
    REG_MAX_DELTA
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/core/fixed_step_frame_timer.sv
// Fixed/variable timestep frame timer.
// Input channel (in_valid/in_stall): one word per frame, in_mode 0 = tick with
// raw timestamp, 1 = restart elapsed-time tracking at that timestamp.
// Output channel (out_valid/out_stall): exactly one result word per input word,
// in order. The result sits in an output register; the next input word is
// taken while it waits, and the block only holds off before writing a new
// result while the previous one is still stalled.
// Config channel (cfg_valid/cfg_ready, always ready): write registers only
// while the block is idle.
// A restart word goes straight to the output state; a tick word runs the
// subtract, multiply and divide steps, in fixed mode a second divide, then
// the total update. A new input word is taken only once the previous one
// has been placed in the output register.
// The time is set by the nibble-serial 64-bit adders, the bit-serial multiply
// and the two restoring dividers (one quotient bit per cycle); the end-of-second
// modulo runs in parallel with them.
// Synchronous reset clears all timing state and restores the register
// defaults; no result is pending after reset.
`default_nettype none

module fixed_step_frame_timer #(
  parameter int unsigned TICK_RATE = fsft_pkg::TICKS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_mode,
  input  wire logic [fsft_pkg::TS_W-1:0]        in_timestamp,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [fsft_pkg::UPD_W-1:0]            out_update_count,
  output logic [fsft_pkg::STEP_W-1:0]           out_elapsed_ticks,
  output logic [fsft_pkg::TS_W-1:0]             out_total_ticks,
  output logic [fsft_pkg::FRM_W-1:0]            out_frame_count,
  output logic [fsft_pkg::FRM_W-1:0]            out_frames_per_second,
  output logic [fsft_pkg::STEP_W-1:0]           out_leftover_ticks,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fsft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fsft_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int TS_W   = fsft_pkg::TS_W;
  localparam int STEP_W = fsft_pkg::STEP_W;
  localparam int FREQ_W = fsft_pkg::FREQ_W;
  localparam int MAXD_W = fsft_pkg::MAXD_W;
  localparam int FRM_W  = fsft_pkg::FRM_W;
  localparam int UPD_W  = fsft_pkg::UPD_W;
  localparam int ISS_W  = fsft_pkg::ISS_W;
  localparam int DIG_W  = fsft_pkg::DIG_W;
  localparam int MX_W   = fsft_pkg::MX_W;

  localparam int TICKS_W = $clog2(TICK_RATE + 1);
  localparam int PW      = MAXD_W + TICKS_W;
  localparam int CNT_W   = $clog2(PW);
  localparam int MC_W    = $clog2(TS_W);

  localparam int unsigned SNAP = TICK_RATE / fsft_pkg::SNAP_DIV;
  localparam logic [STEP_W-1:0] TGT_RST  = STEP_W'(TICK_RATE / fsft_pkg::STEP_RATE);
  localparam logic [STEP_W-1:0] SNAP_LIM = STEP_W'(SNAP);
  localparam logic [TICKS_W:0]  TICKS_K  = (TICKS_W+1)'(TICK_RATE);

  localparam logic [CNT_W-1:0] SUB_LAST  = CNT_W'(TS_W / DIG_W - 1);
  localparam logic [CNT_W-1:0] RAW_DIGS  = CNT_W'(MX_W / DIG_W);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MAXD_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PW - 1);
  localparam logic [CNT_W-1:0] DIV2_LAST = CNT_W'(ISS_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SUB, S_CLAMP, S_MUL, S_DIV, S_STEP, S_LOAD2, S_DIV2, S_FIX,
    S_TOT, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // config
  logic                fixed_r;
  logic [STEP_W-1:0]   target_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [MAXD_W-1:0]   maxd_r;

  // timing state
  logic [TS_W-1:0]     last_r;
  logic [TS_W-1:0]     acc_r;
  logic [STEP_W-1:0]   leftover_r;
  logic [STEP_W-1:0]   step_r;
  logic [TS_W-1:0]     tt_r;
  logic [FRM_W-1:0]    frames_r;
  logic [FRM_W-1:0]    fts_r;
  logic [FRM_W-1:0]    rate_r;

  // datapath
  logic [CNT_W-1:0]    cnt_r;
  logic [TS_W-1:0]     now_r;
  logic [MX_W-1:0]     mx_r;
  logic [MX_W-1:0]     raw_r;
  logic                br_r;
  logic                cy_r;
  logic                gt_r;
  logic [MAXD_W-1:0]   mq_r;
  logic [PW-1:0]       prod_r;
  logic [FREQ_W-1:0]   rem_r;
  logic [STEP_W-1:0]   q_r;
  logic                ovf_r;
  logic                snap_r;
  logic [ISS_W-1:0]    s_r;
  logic [ISS_W-1:0]    sum_r;
  logic [STEP_W-1:0]   rem2_r;
  logic [ISS_W-1:0]    q2_r;
  logic [ISS_W-1:0]    issued_r;
  logic [ISS_W-1:0]    inc_r;

  // end-of-second modulo
  logic                md_busy_r;
  logic [MC_W-1:0]     md_cnt_r;
  logic [TS_W-1:0]     md_dvd_r;
  logic [FREQ_W-1:0]   md_rem_r;
  logic                md_any_r;

  // output word
  logic                out_valid_r;
  logic [UPD_W-1:0]    o_upd_r;
  logic [STEP_W-1:0]   o_elapsed_r;
  logic [TS_W-1:0]     o_total_r;
  logic [FRM_W-1:0]    o_frames_r;
  logic [FRM_W-1:0]    o_fps_r;
  logic [STEP_W-1:0]   o_left_r;

  logic [FREQ_W-1:0]   fz;
  logic [STEP_W-1:0]   tgt;
  logic [DIG_W:0]      sub_d;
  logic [DIG_W:0]      add_d;
  logic [DIG_W:0]      tt_d;
  logic [DIG_W-1:0]    raw_dig;
  logic [DIG_W-1:0]    mx_dig;
  logic [TICKS_W:0]    mul_t;
  logic [FREQ_W:0]     d1_r2;
  logic                d1_ge;
  logic [FREQ_W:0]     d1_dif;
  logic [STEP_W-1:0]   d_val;
  logic [STEP_W-1:0]   absd;
  logic [ISS_W-1:0]    sum_v;
  logic [ISS_W-1:0]    d2_r2;
  logic                d2_ge;
  logic [ISS_W-1:0]    d2_dif;
  logic [FREQ_W:0]     md_r2;
  logic                md_ge;
  logic [FREQ_W:0]     md_dif;
  logic [FRM_W-1:0]    fts_nxt;
  logic [UPD_W-1:0]    upd_nxt;
  logic                out_free;

  always_comb begin
    fz      = (freq_r == '0) ? FREQ_W'(1) : freq_r;
    tgt     = (target_r == '0) ? STEP_W'(1) : target_r;

    sub_d   = {1'b0, now_r[DIG_W-1:0]} - {1'b0, last_r[DIG_W-1:0]} - (DIG_W+1)'(br_r);
    raw_dig = sub_d[DIG_W-1:0];
    add_d   = {1'b0, acc_r[DIG_W-1:0]} + {1'b0, raw_dig} + (DIG_W+1)'(cy_r);
    mx_dig  = mx_r[DIG_W-1:0];
    tt_d    = {1'b0, tt_r[DIG_W-1:0]} + {1'b0, inc_r[DIG_W-1:0]} + (DIG_W+1)'(cy_r);

    mul_t   = {1'b0, prod_r[PW-1:MAXD_W]} + (mq_r[0] ? TICKS_K : '0);

    d1_r2   = {rem_r, prod_r[PW-1]};
    d1_dif  = d1_r2 - {1'b0, fz};
    d1_ge   = d1_r2 >= {1'b0, fz};
    d_val   = ovf_r ? '1 : q_r;

    absd    = (d_val >= tgt) ? (d_val - tgt) : (tgt - d_val);
    sum_v   = {1'b0, leftover_r} + {1'b0, snap_r ? tgt : d_val};

    d2_r2   = {rem2_r, s_r[ISS_W-1]};
    d2_dif  = d2_r2 - {1'b0, tgt};
    d2_ge   = d2_r2 >= {1'b0, tgt};

    md_r2   = {md_rem_r, md_dvd_r[TS_W-1]};
    md_dif  = md_r2 - {1'b0, fz};
    md_ge   = md_r2 >= {1'b0, fz};

    fts_nxt = fts_r + FRM_W'(issued_r != '0);
    upd_nxt = (issued_r[ISS_W-1:UPD_W] != '0) ? '1 : issued_r[UPD_W-1:0];
    out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fixed_r     <= 1'b0;
      target_r    <= TGT_RST;
      freq_r      <= fsft_pkg::FREQ_RST;
      maxd_r      <= fsft_pkg::MAXD_RST;
      last_r      <= '0;
      acc_r       <= '0;
      leftover_r  <= '0;
      step_r      <= '0;
      tt_r        <= '0;
      frames_r    <= '0;
      fts_r       <= '0;
      rate_r      <= '0;
      md_busy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (fsft_pkg::cfg_reg_t'(cfg_index))
          fsft_pkg::REG_FIXED_STEP:   fixed_r  <= cfg_data[0];
          fsft_pkg::REG_TARGET_STEP:  target_r <= cfg_data[STEP_W-1:0];
          fsft_pkg::REG_COUNTER_FREQ: freq_r   <= cfg_data[FREQ_W-1:0];
          fsft_pkg::REG_MAX_DELTA:    maxd_r   <= cfg_data[MAXD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      if (md_busy_r) begin
        md_dvd_r <= {md_dvd_r[TS_W-2:0], 1'b0};
        md_rem_r <= md_ge ? md_dif[FREQ_W-1:0] : md_r2[FREQ_W-1:0];
        md_any_r <= md_any_r | md_ge;
        md_cnt_r <= md_cnt_r + MC_W'(1);
        if (md_cnt_r == '1) begin
          md_busy_r <= 1'b0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_mode) begin
              last_r     <= in_timestamp;
              leftover_r <= '0;
              rate_r     <= '0;
              fts_r      <= '0;
              acc_r      <= '0;
              issued_r   <= '0;
              state_r    <= S_OUT;
            end else begin
              now_r   <= in_timestamp;
              mx_r    <= MX_W'(maxd_r);
              br_r    <= 1'b0;
              cy_r    <= 1'b0;
              gt_r    <= 1'b0;
              cnt_r   <= '0;
              state_r <= S_SUB;
            end
          end
        end

        // raw = now - last, second accumulator += raw, raw vs max_delta
        S_SUB: begin
          now_r  <= {DIG_W'(0), now_r[TS_W-1:DIG_W]};
          last_r <= {now_r[DIG_W-1:0], last_r[TS_W-1:DIG_W]};
          acc_r  <= {add_d[DIG_W-1:0], acc_r[TS_W-1:DIG_W]};
          mx_r   <= {DIG_W'(0), mx_r[MX_W-1:DIG_W]};
          br_r   <= sub_d[DIG_W];
          cy_r   <= add_d[DIG_W];
          gt_r   <= (raw_dig > mx_dig) || ((raw_dig == mx_dig) && gt_r);
          if (cnt_r < RAW_DIGS) begin
            raw_r <= {raw_dig, raw_r[MX_W-1:DIG_W]};
          end
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == SUB_LAST) begin
            state_r <= S_CLAMP;
          end
        end

        S_CLAMP: begin
          mq_r      <= gt_r ? maxd_r : raw_r[MAXD_W-1:0];
          prod_r    <= '0;
          cnt_r     <= '0;
          md_dvd_r  <= acc_r;
          md_rem_r  <= '0;
          md_any_r  <= 1'b0;
          md_cnt_r  <= '0;
          md_busy_r <= 1'b1;
          state_r   <= S_MUL;
        end

        // LSB-first shift-add by TICK_RATE
        S_MUL: begin
          prod_r <= {mul_t[TICKS_W:1], mul_t[0], prod_r[MAXD_W-1:1]};
          mq_r   <= {1'b0, mq_r[MAXD_W-1:1]};
          if (cnt_r == MUL_LAST) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            q_r     <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end

        // restoring divide by frequency, quotient saturates at 24 bits
        S_DIV: begin
          prod_r <= {prod_r[PW-2:0], 1'b0};
          rem_r  <= d1_ge ? d1_dif[FREQ_W-1:0] : d1_r2[FREQ_W-1:0];
          q_r    <= {q_r[STEP_W-2:0], d1_ge};
          ovf_r  <= ovf_r | q_r[STEP_W-1];
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == DIV_LAST) begin
            state_r <= S_STEP;
          end
        end

        S_STEP: begin
          if (fixed_r) begin
            snap_r  <= absd < SNAP_LIM;
            state_r <= S_LOAD2;
          end else begin
            step_r     <= d_val;
            inc_r      <= {1'b0, d_val};
            leftover_r <= '0;
            frames_r   <= frames_r + FRM_W'(1);
            issued_r   <= ISS_W'(1);
            cy_r       <= 1'b0;
            cnt_r      <= '0;
            state_r    <= S_TOT;
          end
        end

        S_LOAD2: begin
          s_r     <= sum_v;
          sum_r   <= sum_v;
          rem2_r  <= '0;
          q2_r    <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV2;
        end

        S_DIV2: begin
          s_r    <= {s_r[ISS_W-2:0], 1'b0};
          rem2_r <= d2_ge ? d2_dif[STEP_W-1:0] : d2_r2[STEP_W-1:0];
          q2_r   <= {q2_r[ISS_W-2:0], d2_ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == DIV2_LAST) begin
            state_r <= S_FIX;
          end
        end

        S_FIX: begin
          issued_r   <= q2_r;
          leftover_r <= rem2_r;
          if (q2_r != '0) begin
            step_r   <= tgt;
            inc_r    <= sum_r - {1'b0, rem2_r};
            frames_r <= frames_r + FRM_W'(q2_r);
          end else begin
            inc_r <= '0;
          end
          cy_r    <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_TOT;
        end

        S_TOT: begin
          tt_r  <= {tt_d[DIG_W-1:0], tt_r[TS_W-1:DIG_W]};
          inc_r <= {DIG_W'(0), inc_r[ISS_W-1:DIG_W]};
          cy_r  <= tt_d[DIG_W];
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == SUB_LAST) begin
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          if (md_any_r) begin
            rate_r <= fts_nxt;
            fts_r  <= '0;
            acc_r  <= TS_W'(md_rem_r);
          end else begin
            fts_r <= fts_nxt;
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_upd_r     <= upd_nxt;
            o_elapsed_r <= step_r;
            o_total_r   <= tt_r;
            o_frames_r  <= frames_r;
            o_fps_r     <= rate_r;
            o_left_r    <= leftover_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall              = (state_r != S_IDLE);
  assign cfg_ready             = 1'b1;
  assign out_valid             = out_valid_r;
  assign out_update_count      = o_upd_r;
  assign out_elapsed_ticks     = o_elapsed_r;
  assign out_total_ticks       = o_total_r;
  assign out_frame_count       = o_frames_r;
  assign out_frames_per_second = o_fps_r;
  assign out_leftover_ticks    = o_left_r;

`ifndef SYNTHESIS
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !md_busy_r)
    else $error("second modulo not finished at end of item");

  a_left_lt_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> (leftover_r < tgt))
    else $error("leftover not below target step");

  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word raised outside output state");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;

  localparam int unsigned     TICKS_DEF   = fsft_pkg::TICKS_DEF;
  localparam int              SNAP_DIV    = fsft_pkg::SNAP_DIV;
  localparam int              STEP_RATE   = fsft_pkg::STEP_RATE;
  localparam int              TS_W        = fsft_pkg::TS_W;
  localparam int              STEP_W      = fsft_pkg::STEP_W;
  localparam int              FREQ_W      = fsft_pkg::FREQ_W;
  localparam int              MAXD_W      = fsft_pkg::MAXD_W;
  localparam int              UPD_W       = fsft_pkg::UPD_W;
  localparam int              FRM_W       = fsft_pkg::FRM_W;
  localparam int              CFG_IDX_W   = fsft_pkg::CFG_IDX_W;
  localparam int              CFG_DATA_W  = fsft_pkg::CFG_DATA_W;
  localparam longint unsigned TICKS       = TICKS_DEF;
  localparam longint          SNAP_WIN    = longint'(TICKS_DEF / SNAP_DIV);
  localparam int              QUIET_LIMIT = 10000;
  localparam int              HOLD_CYCLES = 2000;
  localparam int              PHASES      = 8;
  localparam int              PHASE_WORDS = 170;

  typedef struct packed {
    logic [UPD_W-1:0]  update_count;
    logic [STEP_W-1:0] elapsed_ticks;
    logic [TS_W-1:0]   total_ticks;
    logic [FRM_W-1:0]  frame_count;
    logic [FRM_W-1:0]  frames_per_second;
    logic [STEP_W-1:0] leftover_ticks;
  } timer_word_t;

  class timer_scoreboard;
    bit                fixed_mode;
    bit [STEP_W-1:0]   target;
    bit [FREQ_W-1:0]   freq;
    bit [MAXD_W-1:0]   max_raw;
    bit [TS_W-1:0]     last_ts;
    bit [TS_W-1:0]     sec_accum;
    bit [TS_W-1:0]     tick_sum;
    bit [STEP_W-1:0]   leftover;
    bit [STEP_W-1:0]   step_len;
    bit [FRM_W-1:0]    frames;
    bit [FRM_W-1:0]    frames_sec;
    bit [FRM_W-1:0]    fps;
    timer_word_t       pending_words[$];
    int                mismatches;
    int                checked;

    function new();
      fixed_mode = 1'b0;
      target     = STEP_W'(TICKS_DEF / STEP_RATE);
      freq       = fsft_pkg::FREQ_RST;
      max_raw    = fsft_pkg::MAXD_RST;
      last_ts    = '0;
      sec_accum  = '0;
      tick_sum   = '0;
      leftover   = '0;
      step_len   = '0;
      frames     = '0;
      frames_sec = '0;
      fps        = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(fsft_pkg::cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        fsft_pkg::REG_FIXED_STEP:   fixed_mode = data[0];
        fsft_pkg::REG_TARGET_STEP:  target     = data[STEP_W-1:0];
        fsft_pkg::REG_COUNTER_FREQ: freq       = data[FREQ_W-1:0];
        fsft_pkg::REG_MAX_DELTA:    max_raw    = data[MAXD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(bit mode, bit [TS_W-1:0] ts);
      bit [63:0]   fq;
      bit [63:0]   raw;
      bit [63:0]   conv;
      bit [63:0]   tgt;
      bit [63:0]   sum;
      bit [63:0]   issued;
      longint      gap;
      timer_word_t want;
      issued = '0;
      if (mode) begin
        last_ts    = ts;
        leftover   = '0;
        fps        = '0;
        frames_sec = '0;
        sec_accum  = '0;
      end else begin
        fq        = (freq == 0) ? 64'd1 : 64'(freq);
        raw       = ts - last_ts;
        last_ts   = ts;
        sec_accum = sec_accum + raw;
        if (raw > 64'(max_raw)) raw = 64'(max_raw);
        conv = (raw * TICKS) / fq;
        if (conv > 64'hFF_FFFF) conv = 64'hFF_FFFF;
        if (fixed_mode) begin
          tgt = (target == 0) ? 64'd1 : 64'(target);
          gap = longint'(conv) - longint'(tgt);
          if (gap < 0) gap = -gap;
          if (gap < SNAP_WIN) conv = tgt;
          sum      = 64'(leftover) + conv;
          issued   = sum / tgt;
          leftover = STEP_W'(sum % tgt);
          if (issued != 0) begin
            step_len = STEP_W'(tgt);
            tick_sum = tick_sum + issued * tgt;
            frames   = frames + FRM_W'(issued);
          end
        end else begin
          step_len = STEP_W'(conv);
          tick_sum = tick_sum + conv;
          leftover = '0;
          frames   = frames + 1;
          issued   = 64'd1;
        end
        if (issued != 0) frames_sec = frames_sec + 1;
        if (sec_accum >= fq) begin
          fps        = frames_sec;
          frames_sec = '0;
          sec_accum  = sec_accum % fq;
        end
      end
      want.update_count      = (issued > 1023) ? UPD_W'(1023) : UPD_W'(issued);
      want.elapsed_ticks     = step_len;
      want.total_ticks       = tick_sum;
      want.frame_count       = frames;
      want.frames_per_second = fps;
      want.leftover_ticks    = leftover;
      pending_words.push_back(want);
    endfunction

    function void check_word(timer_word_t got);
      timer_word_t want;
      bit          bad;
      checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing outstanding: upd=%0d tot=%0h",
                   checked, got.update_count, got.total_ticks);
        return;
      end
      want = pending_words.pop_front();
      bad = (got.update_count !== want.update_count) ||
            (got.elapsed_ticks !== want.elapsed_ticks) ||
            (got.total_ticks !== want.total_ticks) ||
            (got.frame_count !== want.frame_count) ||
            (got.frames_per_second !== want.frames_per_second) ||
            (got.leftover_ticks !== want.leftover_ticks);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs", checked);
          $display("  exp upd=%0d el=%0d tot=%0h frm=%0d fps=%0d left=%0d",
                   want.update_count, want.elapsed_ticks, want.total_ticks,
                   want.frame_count, want.frames_per_second, want.leftover_ticks);
          $display("  got upd=%0d el=%0d tot=%0h frm=%0d fps=%0d left=%0d",
                   got.update_count, got.elapsed_ticks, got.total_ticks,
                   got.frame_count, got.frames_per_second, got.leftover_ticks);
        end
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [TS_W-1:0]       in_timestamp = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [UPD_W-1:0]      out_update_count;
  logic [STEP_W-1:0]     out_elapsed_ticks;
  logic [TS_W-1:0]       out_total_ticks;
  logic [FRM_W-1:0]      out_frame_count;
  logic [FRM_W-1:0]      out_frames_per_second;
  logic [STEP_W-1:0]     out_leftover_ticks;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  timer_scoreboard sb;
  logic [TS_W-1:0] cur_ts = '0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  int              hold_req = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  int              quiet = 0;

  fixed_step_frame_timer i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_timestamp          (in_timestamp),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_update_count      (out_update_count),
    .out_elapsed_ticks     (out_elapsed_ticks),
    .out_total_ticks       (out_total_ticks),
    .out_frame_count       (out_frame_count),
    .out_frames_per_second (out_frames_per_second),
    .out_leftover_ticks    (out_leftover_ticks),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #1 clk = ~clk;

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_seen <= hold_req;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_word({out_update_count, out_elapsed_ticks, out_total_ticks,
                     out_frame_count, out_frames_per_second, out_leftover_ticks});
    if (!rst_n || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall) || (cfg_valid && cfg_ready === 1'b1)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(bit mode, bit [TS_W-1:0] ts);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_timestamp <= ts;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(mode, ts);
  endtask

  task automatic tick(bit [TS_W-1:0] delta);
    cur_ts = cur_ts + delta;
    send_word(1'b0, cur_ts);
  endtask

  task automatic restart(bit [TS_W-1:0] ts);
    cur_ts = ts;
    send_word(1'b1, ts);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(fsft_pkg::cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(bit fixed, bit [CFG_DATA_W-1:0] tgt, bit [CFG_DATA_W-1:0] fq,
                          bit [CFG_DATA_W-1:0] md);
    wait_idle();
    write_reg(fsft_pkg::REG_FIXED_STEP, CFG_DATA_W'(fixed));
    write_reg(fsft_pkg::REG_TARGET_STEP, tgt);
    write_reg(fsft_pkg::REG_COUNTER_FREQ, fq);
    write_reg(fsft_pkg::REG_MAX_DELTA, md);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int kind);
    bit          fixed;
    bit [31:0]   tgt;
    bit [31:0]   fq;
    bit [31:0]   md;
    bit [63:0]   nom;
    int unsigned win;
    longint      jit;
    int          roll;
    fixed = ($urandom_range(2, 0) != 0);
    case ($urandom_range(3, 0))
      0: tgt = TICKS_DEF / STEP_RATE;
      1: tgt = 333333;
      2: tgt = 69444;
      default: tgt = $urandom_range(10000000, 1000);
    endcase
    case ($urandom_range(4, 0))
      0: fq = 1000;
      1: fq = TICKS_DEF;
      2: fq = 3579545;
      3: fq = $urandom_range(100000000, 1000);
      default: fq = $urandom;
    endcase
    md = ($urandom_range(3, 0) != 0) ? fq / 10 : $urandom_range(429496729, 1);
    set_regs(fixed, tgt, fq, md);
    send_idle_pct = (kind == 1) ? 64 : (kind == 3) ? 16 : 0;
    stall_pct     = (kind == 2) ? 64 : (kind == 3) ? 16 : 0;
    nom = (64'(tgt) * 64'(fq)) / TICKS;
    win = 32'((64'(TICKS_DEF / SNAP_DIV) * 64'(fq)) / TICKS);
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i == 60 && (kind == 2 || kind == 0)) hold_req = hold_req + 1;
      if (i == 110 && kind != 2) wait_idle();
      roll = $urandom_range(99, 0);
      jit  = longint'($urandom_range(2 * win, 0)) - longint'(win);
      if (roll < 60)
        tick(64'(longint'(nom) + jit));
      else if (roll < 75)
        tick(64'(longint'(nom) * $urandom_range(4, 2) + jit));
      else if (roll < 85)
        tick(64'($urandom_range(32'(nom) / 2, 0)));
      else if (roll < 91)
        tick({$urandom, $urandom});
      else if (roll < 94)
        tick(64'(md) + 64'($urandom_range(1, 0)));
      else if (roll < 96)
        tick('0);
      else if (roll < 98)
        restart({$urandom, $urandom});
      else
        restart(cur_ts);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, variable step: wrap, clamp, second rollover
    tick('0);
    tick(64'd166666);
    tick(64'd5000000);
    tick(64'd20000000);
    restart(64'hFFFF_FFFF_FFFF_FF00);
    tick(64'h1100);
    tick(64'hFFFF_FFFF_FFFF_FFFF);

    // small target: snap, catch-up, count saturation
    set_regs(1'b1, 1000, TICKS_DEF, 429496729);
    tick(64'd1000);
    tick(64'd429496730);
    tick(64'd500);
    tick(64'd3700);

    // zero target and zero frequency
    set_regs(1'b1, 0, 0, 1);
    tick(64'd1);
    tick('0);
    restart(64'h8000_0000_0000_0000);
    tick(64'd1);

    // widest register values, no step issued
    set_regs(1'b1, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h1FFF_FFFF);
    tick(64'd1);
    tick(64'h1_0000_0000);
    tick(64'h1_0000_0000);

    set_regs(1'b1, TICKS_DEF / STEP_RATE, TICKS_DEF, 1000000);
    tick(64'd167666);
    tick(64'd160000);
    tick(64'd10);
    restart(cur_ts);

    set_regs(1'b0, 10000000, 1000, 100);
    tick(64'd100);
    tick(64'd1001);

    for (int p = 0; p < PHASES; p++) run_phase(p % 4);

    wait_idle();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
